/* src/pi_current_loop_duty_assert.svh */
// Assertion macros for the PI current loop block.
`ifndef PI_CURRENT_LOOP_DUTY_ASSERT_SVH
`define PI_CURRENT_LOOP_DUTY_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define PCLD_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pcld assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define PCLD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pcld assertion failed");

`endif

/* src/pcld_pkg.sv */
// Shared widths, constants and controller/datapath types for the PI current loop.
package pcld_pkg;

  localparam int CUR_W      = 16;
  localparam int BUS_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 16;
  localparam int DLIM_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = 40;
  localparam int BUSF_W     = 24;
  localparam int ERR_W      = 17;
  localparam int PROD_W     = 34;
  localparam int MAG_W      = 33;
  localparam int REM_W      = 41;
  localparam int QUO_W      = 15;
  localparam int STEP_W     = 4;
  localparam int N10_W      = 28;
  localparam int P10_W      = 60;
  localparam int DIV10_SHIFT = 35;

  localparam logic [31:0]       DIV10_RECIP  = 32'hCCCC_CCCD;
  localparam logic [DLIM_W-1:0] DUTY_LIM_RST = 15'd31130;
  localparam logic [STEP_W-1:0] LAST_STEP    = 4'(QUO_W - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_LIMIT = 3'd2,
    REG_VOLT_LIMIT  = 3'd3,
    REG_DUTY_LIMIT  = 3'd4
  } pcld_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_I,
    OP_ACC,
    OP_MUL_P,
    OP_VSUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DUTY,
    OP_BUS_MUL,
    OP_BUS_WR
  } pcld_op_t;

  typedef struct packed {
    pcld_op_t          op;
    logic [STEP_W-1:0] bit_idx;
    logic              out_ld;
  } pcld_cmd_t;

endpackage

/* src/pcld_in_if.sv */
// Input channel: one beat per PWM tick with command, measurement and bus sample.
interface pcld_in_if;
  import pcld_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    running;
  logic signed [CUR_W-1:0] current_cmd_ma;
  logic signed [CUR_W-1:0] phase_current_ma;
  logic [BUS_W-1:0]        bus_mv;

  modport source (output valid, running, current_cmd_ma, phase_current_ma, bus_mv,
                  input ready);
  modport sink   (input valid, running, current_cmd_ma, phase_current_ma, bus_mv,
                  output ready);
endinterface

/* src/pcld_out_if.sv */
// Result channel: one duty beat per input beat.
interface pcld_out_if;
  import pcld_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DUTY_W-1:0] duty;
  logic                     held;

  modport source (output valid, duty, held, input ready);
  modport sink   (input valid, duty, held, output ready);
endinterface

/* src/pi_current_loop_duty.sv */
// PI current loop with clamped integrator producing a signed Q1.15 PWM duty per tick.
// One result beat follows every input beat. A running beat goes from acceptance to
// the next possible acceptance through PI math (integral multiply, accumulate,
// proportional multiply, voltage sum) on one shared 17x17 multiplier, a divider
// setup step, a restoring divider that forms one duty bit per cycle, a duty step,
// the bus filter (reciprocal multiply by 1/10, then write) and an output step.
// A beat with running low repeats the previous duty with held set.
// The output register lets the next beat be accepted while a result waits to be
// taken. Configuration writes are taken at any time but only while the block is idle
// are they defined to apply cleanly to the next beat.
module pi_current_loop_duty (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcld_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pcld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  pcld_in_if.sink                          in_if,
  pcld_out_if.source                       out_if
);
  import pcld_pkg::*;

  `include "pi_current_loop_duty_assert.svh"

  pcld_cmd_t cmd;

  // Sequencer
  pcld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_running (in_if.running),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .cmd        (cmd)
  );

  // Arithmetic and state
  pcld_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_running (in_if.running),
    .in_cmd_ma  (in_if.current_cmd_ma),
    .in_meas_ma (in_if.phase_current_ma),
    .in_bus_mv  (in_if.bus_mv),
    .cmd        (cmd),
    .out_duty   (out_if.duty),
    .out_held   (out_if.held)
  );

  // An accepted beat blocks further input until its result is formed
  `PCLD_ASSERT_NEXT(a_one_in_flight, in_if.valid && in_if.ready, !in_if.ready)
  // Never overwrite a result that is still waiting to be taken
  `PCLD_ASSERT_IMPLY(a_no_overwrite, cmd.out_ld, !(out_if.valid && !out_if.ready))
  // Duty stays inside the symmetric Q1.15 range
  `PCLD_ASSERT_IMPLY(a_duty_range, out_if.valid, out_if.duty != 16'sh8000)

endmodule

/* src/pcld_dp.sv */
// Datapath: config registers, loop state, shared multiplier, divider and bus filter.
module pcld_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pcld_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pcld_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_running,
  input  logic signed [pcld_pkg::CUR_W-1:0] in_cmd_ma,
  input  logic signed [pcld_pkg::CUR_W-1:0] in_meas_ma,
  input  logic [pcld_pkg::BUS_W-1:0]        in_bus_mv,
  input  pcld_pkg::pcld_cmd_t               cmd,
  output logic signed [pcld_pkg::DUTY_W-1:0] out_duty,
  output logic                              out_held
);
  import pcld_pkg::*;

  // Configuration
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, integ_lim_r, volt_lim_r;
  logic [DLIM_W-1:0] duty_lim_r;

  // Loop state
  logic signed [ACC_W-1:0]  integ_acc_r;
  logic [BUSF_W-1:0]        bus_filt_r;
  logic signed [DUTY_W-1:0] duty_r;

  // Per-item work registers
  logic                     run_r;
  logic signed [ERR_W-1:0]  err_r;
  logic [BUS_W-1:0]         bus_in_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic                     sat_r;
  logic [REM_W-1:0]         rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [P10_W-1:0]         p10_r;
  logic signed [DUTY_W-1:0] out_duty_r;
  logic                     out_held_r;

  // Combinational terms
  logic [GAIN_W-1:0]        mul_a;
  logic signed [ERR_W-1:0]  mul_a_s;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W:0]    acc_sum, acc_lim, acc_clamp;
  logic signed [ACC_W+1:0]  v_sum, v_lim, v_clamp, v_abs;
  logic [REM_W-1:0]         num, dsh15, dsh;
  logic                     take;
  logic [DLIM_W-1:0]        qlim;
  logic [N10_W-1:0]         n10;

  // Shared multiplier: gain times current error
  always_comb begin
    mul_a   = (cmd.op == OP_MUL_I) ? integ_gain_r : prop_gain_r;
    mul_a_s = $signed({1'b0, mul_a});
    mul_p   = PROD_W'(mul_a_s) * PROD_W'(err_r);
  end

  // Integrator update with symmetric clamp
  always_comb begin
    acc_sum = (ACC_W+1)'(integ_acc_r) + (ACC_W+1)'(prod_r);
    acc_lim = $signed({9'b0, integ_lim_r, 16'b0});
    if (acc_sum > acc_lim) begin
      acc_clamp = acc_lim;
    end else if (acc_sum < -acc_lim) begin
      acc_clamp = -acc_lim;
    end else begin
      acc_clamp = acc_sum;
    end
  end

  // Voltage sum with symmetric clamp, split into sign and magnitude
  always_comb begin
    v_sum = $signed({prod_r, 8'b0}) + (ACC_W+2)'(integ_acc_r);
    v_lim = $signed({10'b0, volt_lim_r, 16'b0});
    if (v_sum > v_lim) begin
      v_clamp = v_lim;
    end else if (v_sum < -v_lim) begin
      v_clamp = -v_lim;
    end else begin
      v_clamp = v_sum;
    end
    v_abs = v_clamp[ACC_W+1] ? -v_clamp : v_clamp;
  end

  // Divider terms: restoring division, one quotient bit per step
  always_comb begin
    num   = {mag_r, 8'b0};
    dsh15 = {2'b0, bus_filt_r, 15'b0};
    dsh   = REM_W'(bus_filt_r) << cmd.bit_idx;
    take  = (bus_filt_r != '0) && (rem_r >= dsh);
    if (sat_r || (quo_r > duty_lim_r)) begin
      qlim = duty_lim_r;
    end else begin
      qlim = quo_r;
    end
  end

  // Bus filter numerator: 9*old + sample*256 + 5
  always_comb begin
    n10 = N10_W'({bus_filt_r, 3'b000}) + N10_W'(bus_filt_r) + N10_W'({bus_in_r, 8'b0})
        + N10_W'(5);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      integ_lim_r  <= '0;
      volt_lim_r   <= '0;
      duty_lim_r   <= DUTY_LIM_RST;
    end else if (cfg_we) begin
      unique case (pcld_reg_t'(cfg_idx))
        REG_PROP_GAIN:   prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN:  integ_gain_r <= cfg_wdata;
        REG_INTEG_LIMIT: integ_lim_r  <= cfg_wdata;
        REG_VOLT_LIMIT:  volt_lim_r   <= cfg_wdata;
        REG_DUTY_LIMIT:  duty_lim_r   <= cfg_wdata[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state: integrator, filtered bus, last duty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r <= '0;
      bus_filt_r  <= '0;
      duty_r      <= '0;
    end else begin
      if (cmd.op == OP_ACC) begin
        integ_acc_r <= acc_clamp[ACC_W-1:0];
      end
      if (cmd.op == OP_DUTY) begin
        duty_r <= neg_r ? -$signed({1'b0, qlim}) : $signed({1'b0, qlim});
      end
      if (cmd.op == OP_BUS_WR) begin
        bus_filt_r <= p10_r[DIV10_SHIFT+BUSF_W-1:DIV10_SHIFT];
      end
    end
  end

  // Work registers and output payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        run_r    <= in_running;
        err_r    <= ERR_W'(in_cmd_ma) - ERR_W'(in_meas_ma);
        bus_in_r <= in_bus_mv;
      end
      OP_MUL_I, OP_MUL_P: prod_r <= mul_p;
      OP_VSUM: begin
        neg_r <= v_clamp[ACC_W+1];
        mag_r <= v_abs[MAG_W-1:0];
      end
      OP_DIV_INIT: begin
        sat_r <= (mag_r != '0) && (num >= dsh15);
        rem_r <= num;
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        if (take) begin
          rem_r <= rem_r - dsh;
        end
        quo_r[cmd.bit_idx] <= take;
      end
      OP_BUS_MUL: p10_r <= P10_W'(n10) * P10_W'(DIV10_RECIP);
      default: ;
    endcase
    if (cmd.out_ld) begin
      out_duty_r <= duty_r;
      out_held_r <= !run_r;
    end
  end

  assign out_duty = out_duty_r;
  assign out_held = out_held_r;

endmodule

/* src/pcld_ctrl.sv */
// Controller: sequences one item through the datapath and owns the handshakes.
module pcld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_running,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pcld_pkg::pcld_cmd_t cmd
);
  import pcld_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_I,
    S_ACC,
    S_MUL_P,
    S_VSUM,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DUTY,
    S_BUS_MUL,
    S_BUS_WR,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Decode next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.bit_idx   = cnt_r;
    cmd.out_ld    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = in_running ? S_MUL_I : S_OUT;
        end
      end
      S_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_VSUM;
      end
      S_VSUM: begin
        cmd.op    = OP_VSUM;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = LAST_STEP;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DUTY;
        end
      end
      S_DUTY: begin
        cmd.op    = OP_DUTY;
        state_nxt = S_BUS_MUL;
      end
      S_BUS_MUL: begin
        cmd.op    = OP_BUS_MUL;
        state_nxt = S_BUS_WR;
      end
      S_BUS_WR: begin
        cmd.op    = OP_BUS_WR;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Load the result once the output register is free
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, step count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
